>>> rtl/lfyp_pkg.sv
// Shared types and constants for the LCG-driven Fisher-Yates permutation block.
// Depends on nothing; lfyp_lcg, lfyp_mod and the top level refer to it by scoped names.
package lfyp_pkg;

    // Field widths fixed by the interface.
    localparam int LEN_W = 11;
    localparam int IDX_W = 10;
    localparam int VAL_W = 10;
    localparam int LCG_W = 32;
    localparam int STEP_CW = 5;

    // Generator constants and register reset values.
    localparam logic [LCG_W-1:0] LCG_MUL = 32'd1664525;
    localparam logic [LCG_W-1:0] LCG_INC = 32'd1013904223;
    localparam logic [LCG_W-1:0] SEED_RESET = 32'd20260914;
    localparam logic [LEN_W-1:0] LENGTH_RESET = 11'd1024;

    // Last step of the serial multiply (the multiplier fits in 21 bits)
    // and of the serial remainder (one dividend bit per step).
    localparam logic [STEP_CW-1:0] MUL_LAST = 5'd20;
    localparam logic [STEP_CW-1:0] DIV_LAST = 5'd31;

    // Command codes.
    localparam logic CMD_SHUFFLE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_LENGTH = 1'b0;
    localparam logic CFG_SEED = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] index;
    } t_in;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             index_ok;
    } t_out;

endpackage

>>> rtl/lfyp_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read port.
// Depends on nothing.
module lfyp_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/lfyp_lcg.sv
// Bit-serial LCG step: next = state * LCG_MUL + LCG_INC, mod 2^32.
// Depends on lfyp_pkg; one multiplier bit is consumed per cycle.
module lfyp_lcg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [lfyp_pkg::LCG_W-1:0] i_state,
    output logic                      o_done,
    output logic [lfyp_pkg::LCG_W-1:0] o_value
);

    logic                         r_busy;
    logic                         r_done;
    logic [lfyp_pkg::STEP_CW-1:0] r_cnt;
    logic [lfyp_pkg::LCG_W-1:0]   r_acc;
    logic [lfyp_pkg::LCG_W-1:0]   r_mcand;
    logic [lfyp_pkg::LCG_W-1:0]   n_acc;

    // Add the shifted multiplicand when the current multiplier bit is set.
    always_comb begin
        n_acc = r_acc;
        if (lfyp_pkg::LCG_MUL[r_cnt]) begin
            n_acc = r_acc + r_mcand;
        end
    end

    // Control: start loads the increment, then one bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == lfyp_pkg::MUL_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: accumulator and left-shifting multiplicand.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc   <= lfyp_pkg::LCG_INC;
            r_mcand <= i_state;
        end else if (r_busy) begin
            r_acc   <= n_acc;
            r_mcand <= {r_mcand[lfyp_pkg::LCG_W-2:0], 1'b0};
        end
    end

    assign o_done  = r_done;
    assign o_value = r_acc;

endmodule

>>> rtl/lfyp_mod.sv
// Bit-serial restoring remainder of a 32-bit value by a narrow divisor.
// Depends on lfyp_pkg; one dividend bit is shifted in per cycle.
module lfyp_mod #(
    parameter int IW = 11
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lfyp_pkg::LCG_W-1:0] i_dividend,
    input  logic [IW-1:0]              i_divisor,
    output logic                       o_done,
    output logic [IW-1:0]              o_rem
);

    logic                         r_busy;
    logic                         r_done;
    logic [lfyp_pkg::STEP_CW-1:0] r_cnt;
    logic [lfyp_pkg::LCG_W-1:0]   r_dq;
    logic [IW-1:0]                r_div;
    logic [IW-1:0]                r_rem;
    logic [IW:0]                  rem_sh;
    logic [IW:0]                  rem_sub;
    logic [IW-1:0]                n_rem;

    // Shift in the next dividend bit and subtract the divisor if it fits.
    always_comb begin
        rem_sh  = {r_rem, r_dq[lfyp_pkg::LCG_W-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        if (rem_sh >= {1'b0, r_div}) begin
            n_rem = rem_sub[IW-1:0];
        end else begin
            n_rem = rem_sh[IW-1:0];
        end
    end

    // Control: 32 steps after start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == lfyp_pkg::DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shift register and partial remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dq  <= {r_dq[lfyp_pkg::LCG_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> rtl/lcg_fisher_yates_permutation.sv
// Read: accepted in S_IDLE, answered into the registered output from S_RD once that
// register is free; no new command is taken until then. Shuffle: S_FILL loads the identity,
// then n-1 swap steps, each a serial multiply, a serial remainder, two reads and two writes.
// Reset (synchronous, active low) restores length and seed and clears the generator
// state; the table is not cleared and holds data only after a shuffle.
// Depends on lfyp_pkg, lfyp_ram, lfyp_lcg and lfyp_mod.
module lcg_fisher_yates_permutation #(
    parameter int MAX_LEN = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [lfyp_pkg::LCG_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  lfyp_pkg::t_in                i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output lfyp_pkg::t_out               o_out_data
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int IW = $clog2(MAX_LEN + 1);
    localparam int EW = (IW > lfyp_pkg::LEN_W) ? IW : lfyp_pkg::LEN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_FILL,
        S_MUL,
        S_DIV,
        S_SWRD,
        S_SWW1,
        S_SWW2
    } t_state;

    t_state                     r_state;
    logic [lfyp_pkg::LEN_W-1:0] r_length;
    logic [lfyp_pkg::LCG_W-1:0] r_seed;
    logic [lfyp_pkg::LCG_W-1:0] r_lcg;
    logic [IW-1:0]              r_n;
    logic [IW-1:0]              r_i;
    logic [AW-1:0]              r_cnt;
    logic [AW-1:0]              r_j;
    logic [AW-1:0]              r_a;
    logic                       r_ok;
    logic                       r_lcg_go;
    logic                       r_mod_go;
    logic                       r_out_valid;
    lfyp_pkg::t_out             r_out_data;

    logic [EW-1:0]  eff_len;
    logic [EW-1:0]  len_ext;
    logic           in_fire;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [AW-1:0]  ram_wdata;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    logic [AW-1:0]  ram_rdata;
    logic [AW-1:0]  top_addr;
    logic           lcg_done;
    logic [lfyp_pkg::LCG_W-1:0] lcg_value;
    logic           mod_done;
    logic [IW-1:0]  mod_rem;

    // Effective length saturates at the table depth.
    always_comb begin
        len_ext = EW'(r_length);
        if (len_ext > EW'(MAX_LEN)) begin
            eff_len = EW'(MAX_LEN);
        end else begin
            eff_len = len_ext;
        end
    end

    assign in_fire  = i_in_valid && o_in_ready;
    assign top_addr = AW'(r_i - IW'(1));

    // Table port selection per state.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt;
        ram_wdata = r_cnt;
        ram_re    = 1'b0;
        ram_raddr = AW'(i_in_data.index);
        unique case (r_state)
            S_IDLE: begin
                ram_re = in_fire && (i_in_data.cmd == lfyp_pkg::CMD_READ);
            end
            S_FILL: begin
                ram_we = 1'b1;
            end
            S_MUL: begin
                ram_re    = r_lcg_go;
                ram_raddr = top_addr;
            end
            S_SWRD: begin
                ram_re    = 1'b1;
                ram_raddr = r_j;
            end
            S_SWW1: begin
                ram_we    = 1'b1;
                ram_waddr = top_addr;
                ram_wdata = ram_rdata;
            end
            S_SWW2: begin
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = r_a;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    lfyp_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_LEN)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    lfyp_lcg u_lcg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_lcg_go),
        .i_state (r_lcg),
        .o_done  (lcg_done),
        .o_value (lcg_value)
    );

    lfyp_mod #(
        .IW (IW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_mod_go),
        .i_dividend (r_lcg),
        .i_divisor  (r_i),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // Sequencer, configuration registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_length    <= lfyp_pkg::LENGTH_RESET;
            r_seed      <= lfyp_pkg::SEED_RESET;
            r_lcg       <= '0;
            r_lcg_go    <= 1'b0;
            r_mod_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_lcg_go <= 1'b0;
            r_mod_go <= 1'b0;
            // The result stage reloads the register itself when the beat leaves.
            if (r_out_valid && i_out_ready && (r_state != S_RD)) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == lfyp_pkg::CFG_LENGTH) begin
                    r_length <= i_cfg_data[lfyp_pkg::LEN_W-1:0];
                end else begin
                    r_seed <= i_cfg_data;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_in_data.cmd == lfyp_pkg::CMD_READ) begin
                            r_ok    <= (EW'(i_in_data.index) < eff_len);
                            r_state <= S_RD;
                        end else begin
                            r_lcg <= r_seed;
                            r_n   <= IW'(eff_len);
                            r_cnt <= '0;
                            if (eff_len != '0) begin
                                r_state <= S_FILL;
                            end
                        end
                    end
                end
                S_RD: begin
                    // Hand the beat over once the output register is free.
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid         <= 1'b1;
                        r_out_data.index_ok <= r_ok;
                        r_out_data.value    <= r_ok ? lfyp_pkg::VAL_W'(ram_rdata) : '0;
                        r_state             <= S_IDLE;
                    end
                end
                S_FILL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == AW'(r_n - IW'(1))) begin
                        r_i <= r_n;
                        if (r_n > IW'(1)) begin
                            r_lcg_go <= 1'b1;
                            r_state  <= S_MUL;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_MUL: begin
                    if (lcg_done) begin
                        r_lcg    <= lcg_value;
                        r_a      <= ram_rdata;
                        r_mod_go <= 1'b1;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (mod_done) begin
                        r_j     <= AW'(mod_rem);
                        r_state <= S_SWRD;
                    end
                end
                S_SWRD: begin
                    r_state <= S_SWW1;
                end
                S_SWW1: begin
                    r_state <= S_SWW2;
                end
                S_SWW2: begin
                    if (r_i == IW'(2)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_i      <= r_i - IW'(1);
                        r_lcg_go <= 1'b1;
                        r_state  <= S_MUL;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    // A swap step only runs with a step index between 2 and the latched length.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_i >= IW'(2) && r_i <= r_n))
        else $error("swap step index out of range");

    // The serial remainder always lands below the divisor.
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && mod_done) |-> (mod_rem < r_i))
        else $error("remainder not below divisor");

    // An accepted read goes straight to the result stage.
    a_read_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_data.cmd == lfyp_pkg::CMD_READ) |=> (r_state == S_RD))
        else $error("read beat not routed to result stage");

    // A shuffle never raises a result beat.
    a_no_shuffle_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RD && r_state != S_IDLE) |=> !$rose(r_out_valid))
        else $error("result beat raised during shuffle");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for the LCG-driven Fisher-Yates permutation block.
// Depends on lfyp_pkg and lcg_fisher_yates_permutation; a built-in table model
// predicts every read and a monitor checks it against the output channel.
module tb;

    // Generator constants and register reset values, kept apart from the package.
    localparam logic [lfyp_pkg::LCG_W-1:0] GEN_MUL = 32'd1664525;
    localparam logic [lfyp_pkg::LCG_W-1:0] GEN_INC = 32'd1013904223;
    localparam logic [lfyp_pkg::LCG_W-1:0] SEED_AT_RESET = 32'd20260914;
    localparam logic [lfyp_pkg::LEN_W-1:0] LEN_AT_RESET = 11'd1024;
    localparam int unsigned TABLE_DEPTH = 1024;
    localparam int unsigned STALL_LIMIT = 400000;
    localparam int unsigned ITEM_TARGET = 1400;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic                         i_cfg_idx = lfyp_pkg::CFG_LENGTH;
    logic [lfyp_pkg::LCG_W-1:0]   i_cfg_data = '0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    lfyp_pkg::t_in                i_in_data = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    lfyp_pkg::t_out               o_out_data;

    lcg_fisher_yates_permutation #(
        .MAX_LEN(TABLE_DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Shadow of the permutation table, the generator and the two registers.
    logic [lfyp_pkg::VAL_W-1:0] perm_model [TABLE_DEPTH];
    logic [lfyp_pkg::LCG_W-1:0] gen_state = '0;
    logic [lfyp_pkg::LEN_W-1:0] len_reg = LEN_AT_RESET;
    logic [lfyp_pkg::LCG_W-1:0] seed_reg = SEED_AT_RESET;

    lfyp_pkg::t_in  cmd_q [$];     // commands waiting to be driven
    lfyp_pkg::t_out read_q [$];    // read answers still owed by the block
    int unsigned fault_count = 0;
    int unsigned stall_cycles = 0;
    int unsigned items_queued = 0;
    bit          no_gaps = 1'b0;
    bit          last_was_shuffle = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Lengths beyond the table size saturate to the table size.
    function automatic int unsigned eff_len();
        return (len_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(len_reg);
    endfunction

    // Load the identity and swap from the top index down, one generator step each.
    function automatic void apply_shuffle();
        int unsigned                n;
        int unsigned                j;
        logic [lfyp_pkg::LCG_W-1:0] s;
        logic [lfyp_pkg::VAL_W-1:0] tmp;
        n = eff_len();
        s = seed_reg;
        for (int unsigned i = 0; i < n; i++) begin
            perm_model[i] = i[lfyp_pkg::VAL_W-1:0];
        end
        for (int unsigned i = n; i > 1; i--) begin
            s = s * GEN_MUL + GEN_INC;
            j = s % i;
            tmp = perm_model[i-1];
            perm_model[i-1] = perm_model[j];
            perm_model[j] = tmp;
        end
        gen_state = s;
    endfunction

    function automatic lfyp_pkg::t_out predict_read(input logic [lfyp_pkg::IDX_W-1:0] idx);
        lfyp_pkg::t_out ans;
        ans = '0;
        if (idx < eff_len()) begin
            ans.value = perm_model[idx];
            ans.index_ok = 1'b1;
        end
        return ans;
    endfunction

    // Driver: presents queued commands and updates the model on each accepted beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                if (i_in_data.cmd == lfyp_pkg::CMD_SHUFFLE) begin
                    apply_shuffle();
                end else begin
                    read_q.push_back(predict_read(i_in_data.index));
                end
            end
            if (!i_in_valid || o_in_ready) begin
                if (cmd_q.size() == 0 || (!no_gaps && $urandom_range(99) < 25)) begin
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_data <= cmd_q.pop_front();
                end
            end
        end
    end

    // Monitor: random back-pressure and a field-by-field check of each result beat.
    always @(posedge i_clk) begin
        lfyp_pkg::t_out want;
        i_out_ready <= no_gaps || ($urandom_range(99) >= 25);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (read_q.size() == 0) begin
                $error("result beat with no read pending: value %0d index_ok %0d",
                       o_out_data.value, o_out_data.index_ok);
                fault_count++;
            end else begin
                want = read_q.pop_front();
                if (o_out_data.value !== want.value) begin
                    $error("value mismatch: expected %0d, actual %0d",
                           want.value, o_out_data.value);
                    fault_count++;
                end
                if (o_out_data.index_ok !== want.index_ok) begin
                    $error("index_ok mismatch: expected %0d, actual %0d",
                           want.index_ok, o_out_data.index_ok);
                    fault_count++;
                end
            end
        end
    end

    // Count cycles in which no beat moves on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Wait until every command is taken and every read answered. A shuffle gives
    // no result, so after one the block is given its full walk time as well.
    task automatic drain();
        while (!(cmd_q.size() == 0 && !i_in_valid && read_q.size() == 0)) begin
            @(posedge i_clk);
        end
        repeat (last_was_shuffle ? 72 * eff_len() + 100 : 16) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [lfyp_pkg::LCG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == lfyp_pkg::CFG_LENGTH) begin
            len_reg = data[lfyp_pkg::LEN_W-1:0];
        end else begin
            seed_reg = data;
        end
    endtask

    task automatic add_cmd(input logic cmd, input logic [lfyp_pkg::IDX_W-1:0] idx);
        lfyp_pkg::t_in beat;
        beat.cmd = cmd;
        beat.index = idx;
        cmd_q.push_back(beat);
        last_was_shuffle = (cmd == lfyp_pkg::CMD_SHUFFLE);
        items_queued++;
    endtask

    // Mostly positions inside the current length, the rest anywhere in the field.
    function automatic logic [lfyp_pkg::IDX_W-1:0] pick_index();
        if (eff_len() > 0 && $urandom_range(99) < 65) begin
            return lfyp_pkg::IDX_W'($urandom_range(eff_len() - 1, 0));
        end
        return lfyp_pkg::IDX_W'($urandom_range(TABLE_DEPTH - 1, 0));
    endfunction

    // Stimulus: directed corners first, then random phases of config plus commands.
    initial begin
        int unsigned                pick;
        int unsigned                n;
        logic [lfyp_pkg::LEN_W-1:0] len;
        logic [lfyp_pkg::LCG_W-1:0] seed;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drain();

        // Reset length and seed: every position is in range, so shuffle first.
        add_cmd(lfyp_pkg::CMD_SHUFFLE, 10'd0);
        add_cmd(lfyp_pkg::CMD_READ, 10'd0);
        add_cmd(lfyp_pkg::CMD_READ, 10'd1023);
        add_cmd(lfyp_pkg::CMD_READ, 10'd512);
        add_cmd(lfyp_pkg::CMD_READ, 10'd341);
        add_cmd(lfyp_pkg::CMD_READ, 10'd682);
        drain();

        // Zero length: nothing is written and every read is out of range.
        write_reg(lfyp_pkg::CFG_LENGTH, 32'd0);
        write_reg(lfyp_pkg::CFG_SEED, 32'd0);
        add_cmd(lfyp_pkg::CMD_SHUFFLE, 10'd1023);
        add_cmd(lfyp_pkg::CMD_READ, 10'd0);
        add_cmd(lfyp_pkg::CMD_READ, 10'd1023);
        drain();

        // Length one: a single entry and no swap.
        write_reg(lfyp_pkg::CFG_LENGTH, 32'd1);
        write_reg(lfyp_pkg::CFG_SEED, 32'hFFFF_FFFF);
        add_cmd(lfyp_pkg::CMD_SHUFFLE, 10'd0);
        add_cmd(lfyp_pkg::CMD_READ, 10'd0);
        add_cmd(lfyp_pkg::CMD_READ, 10'd1);
        drain();

        // Length two: one swap, then the first out-of-range position.
        write_reg(lfyp_pkg::CFG_LENGTH, 32'd2);
        write_reg(lfyp_pkg::CFG_SEED, 32'd1);
        add_cmd(lfyp_pkg::CMD_SHUFFLE, 10'd0);
        add_cmd(lfyp_pkg::CMD_READ, 10'd0);
        add_cmd(lfyp_pkg::CMD_READ, 10'd1);
        add_cmd(lfyp_pkg::CMD_READ, 10'd2);
        drain();

        // Largest length register value saturates to the table size.
        write_reg(lfyp_pkg::CFG_LENGTH, 32'd2047);
        write_reg(lfyp_pkg::CFG_SEED, 32'h8000_0000);
        add_cmd(lfyp_pkg::CMD_SHUFFLE, 10'd1023);
        add_cmd(lfyp_pkg::CMD_READ, 10'd0);
        add_cmd(lfyp_pkg::CMD_READ, 10'd1023);
        drain();

        // Length shrunk after a shuffle: reads check against the new length.
        write_reg(lfyp_pkg::CFG_LENGTH, 32'd5);
        add_cmd(lfyp_pkg::CMD_READ, 10'd4);
        add_cmd(lfyp_pkg::CMD_READ, 10'd5);
        add_cmd(lfyp_pkg::CMD_READ, 10'd1023);

        // Random phases; a few in the middle run with no gaps on either side.
        for (int phase = 0; items_queued < ITEM_TARGET; phase++) begin
            drain();
            no_gaps = (phase >= 2 && phase < 5);

            pick = $urandom_range(99);
            if (pick < 5) begin
                len = '0;
            end else if (pick < 10) begin
                len = 11'd1;
            end else if (pick < 13) begin
                len = lfyp_pkg::LEN_W'($urandom_range(2047, 1024));
            end else if (pick < 23) begin
                len = lfyp_pkg::LEN_W'($urandom_range(256, 64));
            end else begin
                len = lfyp_pkg::LEN_W'($urandom_range(40, 2));
            end
            pick = $urandom_range(99);
            seed = (pick < 20) ? '0 : (pick < 30) ? '1 : lfyp_pkg::LCG_W'($urandom);

            // Sometimes only one register changes between phases.
            pick = $urandom_range(99);
            if (pick >= 15) begin
                write_reg(lfyp_pkg::CFG_LENGTH, lfyp_pkg::LCG_W'(len));
            end
            if (pick < 15 || pick >= 30) begin
                write_reg(lfyp_pkg::CFG_SEED, seed);
            end

            n = $urandom_range(60, 20);
            if ($urandom_range(99) < 85) begin
                add_cmd(lfyp_pkg::CMD_SHUFFLE, pick_index());
            end else begin
                add_cmd(lfyp_pkg::CMD_READ, pick_index());
            end
            for (int unsigned k = 1; k < n; k++) begin
                if (eff_len() <= 64 && $urandom_range(99) < 4) begin
                    add_cmd(lfyp_pkg::CMD_SHUFFLE, pick_index());
                end else begin
                    add_cmd(lfyp_pkg::CMD_READ, pick_index());
                end
            end
        end
        drain();

        if (fault_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
